>>> rtl/core/nearest_knot_allocator_core_defines.svh
// Assertion helpers for the nearest-knot allocator core.
`ifndef NEAREST_KNOT_ALLOCATOR_CORE_DEFINES_SVH
`define NEAREST_KNOT_ALLOCATOR_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define NKA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define NKA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/nka_pkg.sv
`timescale 1ns / 1ps

package nka_pkg;

   // Default sizing of the core
   localparam int DEF_MAX_MARGINS    = 8;
   localparam int DEF_MAX_HALF_KNOTS = 15;
   localparam int DEF_VALUE_BITS     = 32;

   // Fixed field widths
   localparam int OPCODE_BITS = 2;
   localparam int MARGIN_BITS = 3;
   localparam int SLOT_FIELD_BITS = 5;
   localparam int HALF_BITS   = 4;
   localparam int SCALE_BITS  = 31;
   localparam int ALLOC_BITS  = 5;
   localparam int FRAC_BITS   = 16;

   // Scale after reset: 1.0 in unsigned Q15.16
   localparam logic [SCALE_BITS-1:0] ONE_Q16 = 31'h0001_0000;

   // Transaction opcodes
   localparam logic [OPCODE_BITS-1:0] OP_SET_MARGIN = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_LOAD_KNOT  = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_CLASSIFY   = 2'd2;

endpackage

>>> rtl/core/nka_ram.sv
`timescale 1ns / 1ps

module nka_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 256,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register one read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/nearest_knot_allocator_core.sv
`timescale 1ns / 1ps
// Nearest-knot allocator core.
// Request channel (req_*): one transaction per item. Opcode set-margin writes a
// margin's intercept, scale and half count K; load-knot writes one raw knot; both
// give no response. Classify maps every knot of its margin to intercept + scale *
// knot and answers with the signed index -K..K of the mapped knot nearest the
// sample (the later knot on a tie), with margin and last flag.
// Response channel (rsp_*): one transaction per classify on a margin in range.
// req_stall is high from acceptance of a classify until its result is loaded into
// the output register, so the core takes no other request meanwhile. The knot
// memory's single read port streams one knot per cycle.
// The response sits in an output register: while rsp_stall holds it, the core
// still takes load and set transactions and starts the next classify, which then
// waits at its end until the register is free.
// Reset clears the margin valid bits (intercept 0, scale 1.0, K 0) and all control;
// knots read back undefined until loaded. No clearing pass is needed.

`include "nearest_knot_allocator_core_defines.svh"

module nearest_knot_allocator_core #(
   parameter int MAX_MARGINS    = nka_pkg::DEF_MAX_MARGINS,
   parameter int MAX_HALF_KNOTS = nka_pkg::DEF_MAX_HALF_KNOTS,
   parameter int VALUE_BITS     = nka_pkg::DEF_VALUE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [nka_pkg::OPCODE_BITS-1:0]        req_opcode,
   input  logic [nka_pkg::MARGIN_BITS-1:0]        req_margin,
   input  logic [nka_pkg::SLOT_FIELD_BITS-1:0]    req_knot_slot,
   input  logic [nka_pkg::HALF_BITS-1:0]          req_half_count,
   input  logic signed [VALUE_BITS-1:0]           req_value,
   input  logic [nka_pkg::SCALE_BITS-1:0]         req_scale,
   input  logic                                   req_last_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [nka_pkg::MARGIN_BITS-1:0]        rsp_margin_out,
   output logic signed [nka_pkg::ALLOC_BITS-1:0]  rsp_allocation,
   output logic                                   rsp_last_out
);

   localparam int HALF_BITS   = nka_pkg::HALF_BITS;
   localparam int SCALE_BITS  = nka_pkg::SCALE_BITS;
   localparam int FRAC_BITS   = nka_pkg::FRAC_BITS;
   localparam int ALLOC_BITS  = nka_pkg::ALLOC_BITS;
   localparam int MARGIN_BITS = nka_pkg::MARGIN_BITS;

   localparam int KNOT_STRIDE = 2 * MAX_HALF_KNOTS + 2;
   localparam int KNOT_DEPTH  = MAX_MARGINS * KNOT_STRIDE;
   localparam int KNOT_AW     = $clog2(KNOT_DEPTH);
   localparam int MARGIN_AW   = (MAX_MARGINS > 1) ? $clog2(MAX_MARGINS) : 1;
   localparam int SLOT_BITS   = $clog2(KNOT_STRIDE);
   localparam int IDX_BITS    = (SLOT_BITS + 1 > ALLOC_BITS) ? SLOT_BITS + 1 : ALLOC_BITS;
   localparam int PARAM_BITS  = HALF_BITS + SCALE_BITS + VALUE_BITS;
   localparam int DIFF_BITS   = VALUE_BITS + 1;
   localparam int PROD_BITS   = VALUE_BITS + SCALE_BITS + 1;
   localparam int DIST_BITS   = VALUE_BITS + SCALE_BITS + 2;

   // Sequencer states
   localparam int STATE_BITS = 3;
   localparam logic [STATE_BITS-1:0] S_IDLE   = 3'd0;
   localparam logic [STATE_BITS-1:0] S_PARAM  = 3'd1;
   localparam logic [STATE_BITS-1:0] S_WALK   = 3'd2;
   localparam logic [STATE_BITS-1:0] S_DRAIN  = 3'd3;
   localparam logic [STATE_BITS-1:0] S_FINISH = 3'd4;

   logic [STATE_BITS-1:0] state_ff, state_in;

   // Request decode
   logic                  req_accept;
   logic                  margin_ok;
   logic                  slot_ok;
   logic [MARGIN_AW-1:0]  margin_idx;
   logic [KNOT_AW-1:0]    knot_base;
   logic [HALF_BITS-1:0]  half_sat;
   logic                  mpar_wr_en;
   logic                  mpar_rd_en;
   logic                  knot_wr_en;
   logic                  start;

   // Margin parameter memory and its valid bits
   logic [MAX_MARGINS-1:0] margin_set_ff, margin_set_in;
   logic [PARAM_BITS-1:0]  mpar_wr_data;
   logic [PARAM_BITS-1:0]  mpar_rd_data;
   logic [PARAM_BITS-1:0]  par_word;
   logic                   par_valid_ff;

   // Transaction context
   logic signed [VALUE_BITS-1:0]  sample_ff;
   logic [MARGIN_BITS-1:0]        margin_out_ff;
   logic                          last_flag_ff;
   logic [KNOT_AW-1:0]            base_ff;

   // Margin parameters for the walk
   logic signed [VALUE_BITS-1:0]  icpt;
   logic signed [DIFF_BITS-1:0]   diff_in, diff_ff;
   logic [SCALE_BITS-1:0]         scale_ff;
   logic [HALF_BITS-1:0]          k_ff;
   logic [SLOT_BITS-1:0]          last_ff;
   logic [SLOT_BITS-1:0]          issue_idx_ff;

   // Knot stream pipeline
   logic                          knot_rd_en;
   logic [KNOT_AW-1:0]            knot_rd_addr;
   logic [KNOT_AW-1:0]            knot_wr_addr;
   logic [VALUE_BITS-1:0]         knot_rd_data;
   logic                          rd_v_ff;
   logic [SLOT_BITS-1:0]          rd_idx_ff;
   logic signed [PROD_BITS-1:0]   prod_in, prod_ff;
   logic                          mul_v_ff;
   logic [SLOT_BITS-1:0]          mul_idx_ff;
   logic signed [DIST_BITS-1:0]   d_scaled;
   logic signed [DIST_BITS-1:0]   d_prod;
   logic signed [DIST_BITS-1:0]   d_val;
   logic [DIST_BITS-1:0]          dist_in, dist_ff;
   logic                          dist_v_ff;
   logic [SLOT_BITS-1:0]          dist_idx_ff;
   logic [DIST_BITS-1:0]          best_dist_ff;
   logic [SLOT_BITS-1:0]          best_idx_ff;
   logic                          take;

   // Response register
   logic                          rsp_load;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0]           alloc_in;
   logic [ALLOC_BITS-1:0]         rsp_alloc_ff;
   logic [MARGIN_BITS-1:0]        rsp_margin_ff;
   logic                          rsp_last_ff;

   // Accept one transaction at a time
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign margin_ok  = (32'(req_margin) < MAX_MARGINS);
   assign slot_ok    = (32'(req_knot_slot) < KNOT_STRIDE);
   assign margin_idx = MARGIN_AW'(req_margin);
   assign knot_base  = KNOT_AW'(32'(margin_idx) * KNOT_STRIDE);
   assign half_sat   = (32'(req_half_count) > MAX_HALF_KNOTS) ?
                       HALF_BITS'(MAX_HALF_KNOTS) : req_half_count;

   // Decode the opcode; ignore margins out of range
   always_comb begin
      mpar_wr_en = 1'b0;
      mpar_rd_en = 1'b0;
      knot_wr_en = 1'b0;
      start      = 1'b0;
      if (req_accept && margin_ok) begin
         unique case (req_opcode)
            nka_pkg::OP_SET_MARGIN: begin
               mpar_wr_en = 1'b1;
            end
            nka_pkg::OP_LOAD_KNOT: begin
               knot_wr_en = slot_ok;
            end
            nka_pkg::OP_CLASSIFY: begin
               mpar_rd_en = 1'b1;
               start      = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign mpar_wr_data = {half_sat, req_scale, req_value};
   assign knot_wr_addr = knot_base + KNOT_AW'(req_knot_slot);

   // Mark a margin written
   always_comb begin
      margin_set_in = margin_set_ff;
      if (mpar_wr_en) begin
         margin_set_in[margin_idx] = 1'b1;
      end
   end

   nka_ram #(
      .WIDTH (PARAM_BITS),
      .DEPTH (MAX_MARGINS)
   ) u_margin_ram (
      .clock   (clock),
      .wr_en   (mpar_wr_en),
      .wr_addr (margin_idx),
      .wr_data (mpar_wr_data),
      .rd_en   (mpar_rd_en),
      .rd_addr (margin_idx),
      .rd_data (mpar_rd_data)
   );

   // Unwritten margins read as their reset values
   assign par_word = par_valid_ff ? mpar_rd_data :
                     {HALF_BITS'(0), nka_pkg::ONE_Q16, VALUE_BITS'(0)};
   assign icpt     = $signed(par_word[VALUE_BITS-1:0]);
   assign diff_in  = {sample_ff[VALUE_BITS-1], sample_ff} - {icpt[VALUE_BITS-1], icpt};

   // Walk the knots of the margin, one read per cycle
   assign knot_rd_en   = (state_ff == S_WALK);
   assign knot_rd_addr = base_ff + KNOT_AW'(issue_idx_ff);

   nka_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (KNOT_DEPTH)
   ) u_knot_ram (
      .clock   (clock),
      .wr_en   (knot_wr_en),
      .wr_addr (knot_wr_addr),
      .wr_data (req_value),
      .rd_en   (knot_rd_en),
      .rd_addr (knot_rd_addr),
      .rd_data (knot_rd_data)
   );

   // Scale the knot
   assign prod_in = $signed({1'b0, scale_ff}) * $signed(knot_rd_data);

   // Exact distance in units of 2^-16
   assign d_scaled = {{(DIST_BITS - DIFF_BITS - FRAC_BITS){diff_ff[DIFF_BITS-1]}},
                      diff_ff, FRAC_BITS'(0)};
   assign d_prod   = {{(DIST_BITS - PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};
   assign d_val    = d_scaled - d_prod;
   assign dist_in  = d_val[DIST_BITS-1] ? DIST_BITS'(-d_val) : DIST_BITS'(d_val);

   // Keep the nearest so far; the later knot wins a tie
   assign take = dist_v_ff && ((dist_idx_ff == '0) || (dist_ff <= best_dist_ff));

   // Sequence the classify
   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_PARAM;
         end
         S_PARAM: begin
            state_in = S_WALK;
         end
         S_WALK: begin
            if (issue_idx_ff == last_ff) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!rd_v_ff && !mul_v_ff && !dist_v_ff) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign alloc_in     = IDX_BITS'(best_idx_ff) - IDX_BITS'(k_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         margin_set_ff <= '0;
         rd_v_ff       <= 1'b0;
         mul_v_ff      <= 1'b0;
         dist_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         margin_set_ff <= margin_set_in;
         rd_v_ff       <= knot_rd_en;
         mul_v_ff      <= rd_v_ff;
         dist_v_ff     <= mul_v_ff;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      // Capture the classify context
      if (start) begin
         sample_ff     <= req_value;
         margin_out_ff <= req_margin;
         last_flag_ff  <= req_last_sample;
         base_ff       <= knot_base;
         par_valid_ff  <= margin_set_ff[margin_idx];
      end
      // Load the margin parameters
      if (state_ff == S_PARAM) begin
         diff_ff      <= diff_in;
         scale_ff     <= par_word[VALUE_BITS +: SCALE_BITS];
         k_ff         <= par_word[VALUE_BITS + SCALE_BITS +: HALF_BITS];
         last_ff      <= SLOT_BITS'({par_word[VALUE_BITS + SCALE_BITS +: HALF_BITS], 1'b0});
         issue_idx_ff <= '0;
      end else if (knot_rd_en && (issue_idx_ff != last_ff)) begin
         issue_idx_ff <= issue_idx_ff + SLOT_BITS'(1);
      end
      // Advance the knot stream
      if (knot_rd_en) begin
         rd_idx_ff <= issue_idx_ff;
      end
      if (rd_v_ff) begin
         prod_ff    <= prod_in;
         mul_idx_ff <= rd_idx_ff;
      end
      if (mul_v_ff) begin
         dist_ff     <= dist_in;
         dist_idx_ff <= mul_idx_ff;
      end
      if (take) begin
         best_dist_ff <= dist_ff;
         best_idx_ff  <= dist_idx_ff;
      end
      // Fill the response register
      if (rsp_load) begin
         rsp_alloc_ff  <= alloc_in[ALLOC_BITS-1:0];
         rsp_margin_ff <= margin_out_ff;
         rsp_last_ff   <= last_flag_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_margin_out = rsp_margin_ff;
   assign rsp_allocation = $signed(rsp_alloc_ff);
   assign rsp_last_out   = rsp_last_ff;

   // Checks
   `NKA_ASSERT_SAME(a_pipe_in_walk, clock, reset,
      mul_v_ff || dist_v_ff, state_ff == S_WALK || state_ff == S_DRAIN,
      "knot pipeline busy outside the walk")
   `NKA_ASSERT_SAME(a_issue_bound, clock, reset,
      state_ff == S_WALK, issue_idx_ff <= last_ff,
      "knot read index beyond the last knot")
   `NKA_ASSERT_SAME(a_best_bound, clock, reset,
      state_ff == S_FINISH, best_idx_ff <= last_ff,
      "nearest knot index beyond the last knot")
   `NKA_ASSERT_NEXT(a_finish_response, clock, reset,
      rsp_load, rsp_valid_ff && state_ff == S_IDLE,
      "finished classify did not present its response")

endmodule
